[hw/rtl/cmf_pkg.sv]
// shared types, constants and helpers of the 3x3 mask filter
`default_nettype none
package cmf_pkg;

	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 512;

	localparam int PIX_W      = 8;
	localparam int DIM_W      = 10;
	localparam int MODE_W     = 3;
	localparam int THR_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [PIX_W-1:0] PAD_VALUE = 8'd127;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

	// reset values of the registers
	localparam logic [DIM_W-1:0]  WIDTH_RST     = 10'd512;
	localparam logic [DIM_W-1:0]  HEIGHT_RST    = 10'd512;
	localparam logic [MODE_W-1:0] MODE_RST      = 3'd0;
	localparam logic [THR_W-1:0]  THRESHOLD_RST = 9'd30;

	// filter modes
	localparam logic [MODE_W-1:0] MODE_EMBOSS = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MEAN   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HDIFF  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_VDIFF  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_EDGE   = 3'd4;

	// floor(sum / 9) == (sum * 3641) >> 15 for any sum of nine bytes
	localparam int             MEAN_SHIFT = 15;
	localparam logic [11:0]    MEAN_RECIP = 12'd3641;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             pad_item;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             frame_last;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_wr_t;

	// geometry already saturated to its legal range
	typedef struct packed {
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [MODE_W-1:0] mode;
		logic [THR_W-1:0]  threshold;
	} cfg_t;

	// right column of the window plus position flags, from the line buffer
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
		logic             first_col;
		logic             emit;
		logic             last;
	} win_col_t;

	function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [11:0] v);
		logic [PIX_W-1:0] r;
		if (v < 12'sd0) begin
			r = 8'd0;
		end else if (v > 12'sd255) begin
			r = 8'd255;
		end else begin
			r = v[PIX_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/cmf_stream_if.sv]
// valid/ready channel carrying one payload word per transaction
`default_nettype none
interface cmf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/cmf_cfg_regs.sv]
// configuration registers with geometry saturation
`default_nettype none
module cmf_cfg_regs #(
	parameter int MAX_WIDTH  = cmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cmf_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	cmf_stream_if.sink        cfg,
	output cmf_pkg::cfg_t     cfg_val
);
	logic [cmf_pkg::DIM_W-1:0]  width_q;
	logic [cmf_pkg::DIM_W-1:0]  height_q;
	logic [cmf_pkg::MODE_W-1:0] mode_q;
	logic [cmf_pkg::THR_W-1:0]  thr_q;
	logic                       wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cmf_pkg::WIDTH_RST;
			height_q <= cmf_pkg::HEIGHT_RST;
			mode_q   <= cmf_pkg::MODE_RST;
			thr_q    <= cmf_pkg::THRESHOLD_RST;
		end else if (wr) begin
			unique case (cfg.data.index)
				cmf_pkg::REG_WIDTH:     width_q  <= cfg.data.value;
				cmf_pkg::REG_HEIGHT:    height_q <= cfg.data.value;
				cmf_pkg::REG_MODE:      mode_q   <= cfg.data.value[cmf_pkg::MODE_W-1:0];
				cmf_pkg::REG_THRESHOLD: thr_q    <= cfg.data.value[cmf_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate geometry to 1..max
	always_comb begin
		if (width_q == '0) begin
			cfg_val.width = cmf_pkg::DIM_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			cfg_val.width = cmf_pkg::DIM_W'(MAX_WIDTH);
		end else begin
			cfg_val.width = width_q;
		end
		if (height_q == '0) begin
			cfg_val.height = cmf_pkg::DIM_W'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			cfg_val.height = cmf_pkg::DIM_W'(MAX_HEIGHT);
		end else begin
			cfg_val.height = height_q;
		end
		cfg_val.mode      = mode_q;
		cfg_val.threshold = thr_q;
	end
endmodule
`default_nettype wire

[hw/rtl/cmf_line_buf.sv]
// raster counters and the two row memories feeding the window's right column
`default_nettype none
module cmf_line_buf #(
	parameter int MAX_WIDTH  = cmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cmf_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cmf_stream_if.sink         pix_in,
	input  wire cmf_pkg::cfg_t cfg_val,
	input  wire logic          take,
	output logic               col_valid,
	output cmf_pkg::win_col_t  col
);
	localparam int DEPTH = MAX_WIDTH + 1;
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = ((CW > RW) ? CW : RW) > cmf_pkg::DIM_W ?
		((CW > RW) ? CW : RW) : cmf_pkg::DIM_W;

	logic [cmf_pkg::PIX_W-1:0] older_mem [DEPTH];
	logic [cmf_pkg::PIX_W-1:0] newer_mem [DEPTH];

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic                      valid_s1;
	logic [CW-1:0]             addr_s1;
	logic [cmf_pkg::PIX_W-1:0] bot_s1;
	logic                      row_ge1_s1;
	logic                      row_ge2_s1;
	logic                      first_col_s1;
	logic                      emit_s1;
	logic                      last_s1;
	logic [cmf_pkg::PIX_W-1:0] older_rd_s1;
	logic [cmf_pkg::PIX_W-1:0] newer_rd_s1;

	logic                      accept;
	logic                      advance;
	logic                      col_end;
	logic                      row_end;
	logic [cmf_pkg::PIX_W-1:0] bot;

	assign advance      = valid_s1 && take;
	assign pix_in.ready = !valid_s1 || take;
	assign accept       = pix_in.valid && pix_in.ready;

	assign col_end = XW'(col_q) >= XW'(cfg_val.width);
	assign row_end = XW'(row_q) >= XW'(cfg_val.height);
	assign bot     = (pix_in.data.pad_item || col_end || row_end) ?
		cmf_pkg::PAD_VALUE : pix_in.data.pixel_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1      <= col_q;
			bot_s1       <= bot;
			row_ge1_s1   <= row_q != '0;
			row_ge2_s1   <= row_q > RW'(1);
			first_col_s1 <= col_q == '0;
			emit_s1      <= (row_q != '0) && (col_q != '0);
			last_s1      <= col_end && row_end;
		end
	end

	// row memories: read when the item enters, rotate when it leaves
	always_ff @(posedge clk) begin
		if (accept) begin
			older_rd_s1 <= older_mem[col_q];
		end
		if (advance) begin
			older_mem[addr_s1] <= newer_rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			newer_rd_s1 <= newer_mem[col_q];
		end
		if (advance) begin
			newer_mem[addr_s1] <= bot_s1;
		end
	end

	assign col_valid     = valid_s1;
	assign col.top       = row_ge2_s1 ? older_rd_s1 : cmf_pkg::PAD_VALUE;
	assign col.mid       = row_ge1_s1 ? newer_rd_s1 : cmf_pkg::PAD_VALUE;
	assign col.bot       = bot_s1;
	assign col.first_col = first_col_s1;
	assign col.emit      = emit_s1;
	assign col.last      = last_s1;
endmodule
`default_nettype wire

[hw/rtl/cmf_window_calc.sv]
// 3x3 window registers, mask arithmetic and the result register
`default_nettype none
module cmf_window_calc (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmf_pkg::cfg_t     cfg_val,
	input  wire logic              col_valid,
	input  wire cmf_pkg::win_col_t col,
	output logic                   take,
	cmf_stream_if.source           pix_out
);
	logic [cmf_pkg::PIX_W-1:0] win_q [6];
	logic                      out_valid_q;
	cmf_pkg::out_item_t        out_q;

	logic [cmf_pkg::PIX_W-1:0] lt, lm, lb, ct, cm, cb;
	logic [11:0]               sum;
	logic [23:0]               prod;
	logic signed [11:0]        emb, hd, vd, ed;
	logic [cmf_pkg::PIX_W-1:0] edge_mag;
	logic [cmf_pkg::PIX_W-1:0] res;
	logic                      advance;

	assign take    = !out_valid_q || pix_out.ready;
	assign advance = col_valid && take;

	// a new row starts with padding on the left
	assign lt = col.first_col ? cmf_pkg::PAD_VALUE : win_q[0];
	assign lm = col.first_col ? cmf_pkg::PAD_VALUE : win_q[1];
	assign lb = col.first_col ? cmf_pkg::PAD_VALUE : win_q[2];
	assign ct = col.first_col ? cmf_pkg::PAD_VALUE : win_q[3];
	assign cm = col.first_col ? cmf_pkg::PAD_VALUE : win_q[4];
	assign cb = col.first_col ? cmf_pkg::PAD_VALUE : win_q[5];

	always_comb begin
		sum = 12'(lt) + 12'(lm) + 12'(lb) + 12'(ct) + 12'(cm) + 12'(cb)
			+ 12'(col.top) + 12'(col.mid) + 12'(col.bot);
		prod     = 24'(sum) * 24'(cmf_pkg::MEAN_RECIP);
		emb      = $signed(12'(lt)) - $signed(12'(col.bot)) + 12'sd127;
		hd       = $signed(12'(cm)) - $signed(12'(lm));
		vd       = $signed(12'(cm)) - $signed(12'(ct));
		ed       = $signed({3'b000, cm, 1'b0}) - $signed(12'(ct)) - $signed(12'(lm));
		edge_mag = cmf_pkg::clamp_byte(ed);
		unique case (cfg_val.mode)
			cmf_pkg::MODE_EMBOSS: res = cmf_pkg::clamp_byte(emb);
			cmf_pkg::MODE_MEAN:   res = prod[cmf_pkg::MEAN_SHIFT +: cmf_pkg::PIX_W];
			cmf_pkg::MODE_HDIFF:  res = cmf_pkg::clamp_byte(hd);
			cmf_pkg::MODE_VDIFF:  res = cmf_pkg::clamp_byte(vd);
			cmf_pkg::MODE_EDGE:   res = ({1'b0, edge_mag} < cfg_val.threshold) ?
				8'd0 : 8'd255;
			default:              res = cm;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= cmf_pkg::PAD_VALUE;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				win_q[0] <= ct;
				win_q[1] <= cm;
				win_q[2] <= cb;
				win_q[3] <= col.top;
				win_q[4] <= col.mid;
				win_q[5] <= col.bot;
			end
			if (take) begin
				out_valid_q <= advance && col.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && col.emit) begin
			out_q.pixel_out  <= res;
			out_q.frame_last <= col.last;
		end
	end

	assign pix_out.valid = out_valid_q;
	assign pix_out.data  = out_q;
endmodule
`default_nettype wire

[hw/rtl/conv3x3_mask_filter_unit.sv]
// top level of the streaming 3x3 mask filter
//
// Pixels enter on pix_in in raster order over a grid of (height+1) rows by
// (width+1) columns; the last column and the last row are pad positions.
// Every item from the second row and second column on yields one result on
// pix_out for the window centred one row up and one column left; the others
// yield nothing. frame_last marks the final centre of the frame.
// Registers are written through cfg (always ready); the user must write
// them only while the block is idle, which the block does not enforce.
// An accepted item is registered with its row-memory read and loads the
// result register when it advances. One item per cycle is sustained while
// pix_out is ready; each row memory is read and written in the same cycle.
// When pix_out stalls, the result register holds and pix_in.ready drops
// only once the input stage is also full.
// Reset clears the raster counters, loads the window with the pad value and
// restores the register defaults; row memory contents are undefined until
// the first row of a frame writes them.
`default_nettype none
module conv3x3_mask_filter_unit #(
	parameter int MAX_WIDTH  = cmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cmf_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	cmf_stream_if.sink   pix_in,
	cmf_stream_if.source pix_out,
	cmf_stream_if.sink   cfg
);
	cmf_pkg::cfg_t     cfg_val;
	cmf_pkg::win_col_t col;
	logic              col_valid;
	logic              take;

	cmf_cfg_regs #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_val(cfg_val)
	);

	cmf_line_buf #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in),
		.cfg_val  (cfg_val),
		.take     (take),
		.col_valid(col_valid),
		.col      (col)
	);

	cmf_window_calc u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_val  (cfg_val),
		.col_valid(col_valid),
		.col      (col),
		.take     (take),
		.pix_out  (pix_out)
	);
endmodule
`default_nettype wire
